>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the cache RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and active-low reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block's default clock and reset (clk_i, rst_ni).
`define ASSERT_DFLT(label, prop, msg) \
  `ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/ttlc_pkg.sv
// ----------------------------------------------------------------------------
// ttlc_pkg
// Sizes, codes, hash constants and entry layout of the TTL attribute cache.
// ----------------------------------------------------------------------------
package ttlc_pkg;

  localparam int unsigned NUM_SETS = 64;
  localparam int unsigned NUM_WAYS = 4;
  localparam int unsigned ENTRIES  = NUM_SETS * NUM_WAYS;
  localparam int unsigned SET_W    = $clog2(NUM_SETS);
  localparam int unsigned WAY_W    = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned ENT_W    = $clog2(ENTRIES);
  localparam bit          SETS_POW2 = ((NUM_SETS & (NUM_SETS - 1)) == 0);

  localparam int unsigned MODE_W = 2;
  localparam int unsigned KEY_W  = 64;
  localparam int unsigned TIME_W = 64;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned TTL_W  = 40;

  localparam logic [63:0] MIX_MUL_A = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] MIX_MUL_B = 64'hFF51_AFD7_ED55_8CCD;
  localparam int unsigned MIX_SHIFT = 33;

  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(50_000_000);

  // APB register map: 64-bit registers at byte offsets 0 and 8.
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 64;
  localparam logic        REG_ENABLE = 1'b0;
  localparam logic        REG_TTL    = 1'b1;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_STORE  = 2'd1,
    MODE_INVAL  = 2'd2
  } mode_e;

  typedef struct packed {
    logic [KEY_W-1:0]  device;
    logic [KEY_W-1:0]  inode;
    logic [TIME_W-1:0] expiry;
    logic [WORD_W-1:0] attr;
    logic [WORD_W-1:0] tag;
  } entry_t;

  function automatic logic [63:0] mix_fold(input logic [63:0] v);
    return v ^ (v >> MIX_SHIFT);
  endfunction

endpackage

>>> rtl/ttlc_if.sv
// ----------------------------------------------------------------------------
// ttlc_if
// Request and response stream interfaces (valid/ready) of the TTL cache.
// ----------------------------------------------------------------------------
interface ttlc_req_if import ttlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [KEY_W-1:0]  device;
  logic [KEY_W-1:0]  inode;
  logic [WORD_W-1:0] new_attr;
  logic [WORD_W-1:0] new_tag;
  logic [TIME_W-1:0] now_ns;

  modport source (output valid, mode, device, inode, new_attr, new_tag, now_ns,
                  input ready);
  modport sink   (input valid, mode, device, inode, new_attr, new_tag, now_ns,
                  output ready);
endinterface

interface ttlc_rsp_if import ttlc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [WORD_W-1:0] found_attr;
  logic [WORD_W-1:0] found_tag;

  modport source (output valid, hit, found_attr, found_tag, input ready);
  modport sink   (input valid, hit, found_attr, found_tag, output ready);
endinterface

>>> rtl/ttlc_ram.sv
// ----------------------------------------------------------------------------
// ttlc_ram
// Generic single-port RAM, one read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module ttlc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

>>> rtl/ttl_set_assoc_attr_cache.sv
// ----------------------------------------------------------------------------
// ttl_set_assoc_attr_cache
// Set-associative (device, inode) attribute cache with per-entry expiry.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          beat contents
//  req_i     in   valid/ready        mode, device, inode, new_attr, new_tag, now_ns
//  rsp_o     out  valid/ready        hit, found_attr, found_tag
//  apb       in   psel/penable       enable @0x0, ttl_ns @0x8 (64-bit data)
//
//  Steps: accept, hash (two 64x64 products on one 32x32 multiplier, three
//  partial products each), set select (for a non-power-of-two set count:
//  four 16-bit digits, a reciprocal pass and a correction pass each), a
//  read and a compare per way scanned on the single-port entry RAM, decide,
//  store write, result.
//  Disabled, zero-key or undefined-mode beats go straight from accept to the result, as a miss.
//  Reset clears per-entry valid bits at once; no clearing pass.
//  A held response stalls only the final result state; the next request is
//  taken as soon as the engine is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ttl_set_assoc_attr_cache import ttlc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ttlc_req_if.sink              req_i,
  ttlc_rsp_if.source            rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // set remainder by digits: x = r * 2^16 + digit, q ~= (x * MOD_M) >> MOD_K
  localparam int unsigned MOD_DW = SET_W + 16;
  localparam int unsigned MOD_K  = 32 + SET_W - 1;
  localparam logic [63:0] MOD_M  = 64'((64'd1 << MOD_K) / 64'(NUM_SETS));

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_MOD, S_RD, S_CMP, S_DECIDE, S_WRITE, S_DONE
  } state_e;

  function automatic logic [ENT_W-1:0] set_base(input logic [SET_W-1:0] s);
    return ENT_W'(s) * ENT_W'(NUM_WAYS);
  endfunction

  // configuration
  logic             enable_q;
  logic [TTL_W-1:0] ttl_q;

  // sequencer and item
  state_e            state_q;
  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  dev_q;
  logic [KEY_W-1:0]  ino_q;
  logic [WORD_W-1:0] attr_in_q;
  logic [WORD_W-1:0] tag_in_q;
  logic [TIME_W-1:0] now_q;

  // hash unit
  logic [63:0] x_q;
  logic [63:0] acc_q;
  logic [1:0]  step_q;
  logic        phase_q;
  logic [1:0]  bit_cnt_q;
  logic [SET_W-1:0] r_q;

  // scan
  logic [ENT_W-1:0]  base_q;
  logic [WAY_W-1:0]  way_q;
  logic              m_found_q;
  logic [WAY_W-1:0]  m_way_q;
  logic [TIME_W-1:0] m_exp_q;
  logic [WORD_W-1:0] m_attr_q;
  logic [WORD_W-1:0] m_tag_q;
  logic              vic_done_q;
  logic [WAY_W-1:0]  vic_way_q;
  logic [TIME_W-1:0] old_exp_q;
  logic [ENTRIES-1:0] valid_q;

  // result
  logic              res_hit_q;
  logic [WORD_W-1:0] res_attr_q;
  logic [WORD_W-1:0] res_tag_q;
  logic              rsp_valid_q;
  logic              rsp_hit_q;
  logic [WORD_W-1:0] rsp_attr_q;
  logic [WORD_W-1:0] rsp_tag_q;

  // combinational
  logic [31:0]       mul_a;
  logic [31:0]       mul_b;
  logic [63:0]       mul_p;
  logic [63:0]       mul_term;
  logic [63:0]       acc_sum;
  logic [63:0]       mul_k;
  logic [MOD_DW-1:0] mod_x;
  logic [MOD_DW-1:0] mod_r;
  logic [SET_W-1:0]  r_next;
  logic [ENT_W-1:0]  ram_addr;
  logic [ENT_W-1:0]  hit_addr;
  logic              ram_we;
  entry_t            ram_wdata;
  entry_t            ram_rdata;
  logic              ent_valid;
  logic              way_match;
  logic              skip_item;
  logic              cfg_wr;

  // ---- configuration port ----
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_comb begin
    if (paddr[3] == REG_TTL) begin
      prdata = {{(CFG_DATA_W - TTL_W){1'b0}}, ttl_q};
    end else begin
      prdata = {{(CFG_DATA_W - 1){1'b0}}, enable_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b1;
      ttl_q    <= TTL_RESET;
    end else if (cfg_wr) begin
      if (paddr[3] == REG_ENABLE) begin
        enable_q <= pwdata[0];
      end else begin
        ttl_q <= pwdata[TTL_W-1:0];
      end
    end
  end

  // ---- shared 32x32 multiplier ----
  // hash: lo*lo, lo*hi, hi*lo (low 64 bits); set select: x*M, then q*N
  assign mul_k = phase_q ? MIX_MUL_B : MIX_MUL_A;
  assign mod_x = {r_q, x_q[63:48]};

  always_comb begin
    if (state_q == S_MOD) begin
      mul_a = step_q[0] ? acc_q[31:0] : 32'(mod_x);
      mul_b = step_q[0] ? 32'(NUM_SETS) : MOD_M[31:0];
    end else begin
      mul_a = (step_q == 2'd2) ? x_q[63:32] : x_q[31:0];
      mul_b = (step_q == 2'd1) ? mul_k[63:32] : mul_k[31:0];
    end
  end

  assign mul_p    = {32'd0, mul_a} * {32'd0, mul_b};
  assign mul_term = (step_q == 2'd0) ? mul_p : {mul_p[31:0], 32'd0};
  assign acc_sum  = acc_q + mul_term;

  // quotient estimate is low by at most one: one conditional subtract
  assign mod_r  = mod_x - mul_p[MOD_DW-1:0];
  assign r_next = (mod_r >= MOD_DW'(NUM_SETS)) ? SET_W'(mod_r - MOD_DW'(NUM_SETS))
                                               : SET_W'(mod_r);

  // ---- entry store ----
  assign hit_addr = base_q + ENT_W'(m_way_q);
  assign ram_addr = (state_q == S_WRITE) ? base_q + ENT_W'(vic_way_q)
                                         : base_q + ENT_W'(way_q);
  assign ram_we   = (state_q == S_WRITE);

  always_comb begin
    ram_wdata        = '0;
    ram_wdata.device = dev_q;
    ram_wdata.inode  = ino_q;
    ram_wdata.expiry = now_q + {{(TIME_W - TTL_W){1'b0}}, ttl_q};
    ram_wdata.attr   = attr_in_q;
    ram_wdata.tag    = tag_in_q;
  end

  ttlc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ent_valid = valid_q[ram_addr];
  assign way_match = ent_valid && (ram_rdata.device == dev_q) && (ram_rdata.inode == ino_q);

  assign skip_item = !enable_q || (req_i.mode != MODE_LOOKUP && req_i.mode != MODE_STORE &&
                     req_i.mode != MODE_INVAL) || (req_i.device == '0) || (req_i.inode == '0);

  // ---- sequencer ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      rsp_valid_q <= 1'b0;
      rsp_hit_q   <= 1'b0;
      rsp_attr_q  <= '0;
      rsp_tag_q   <= '0;
      mode_q      <= '0;
      dev_q       <= '0;
      ino_q       <= '0;
      attr_in_q   <= '0;
      tag_in_q    <= '0;
      now_q       <= '0;
      x_q         <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      phase_q     <= 1'b0;
      bit_cnt_q   <= '0;
      r_q         <= '0;
      base_q      <= '0;
      way_q       <= '0;
      m_found_q   <= 1'b0;
      m_way_q     <= '0;
      m_exp_q     <= '0;
      m_attr_q    <= '0;
      m_tag_q     <= '0;
      vic_done_q  <= 1'b0;
      vic_way_q   <= '0;
      old_exp_q   <= '0;
      res_hit_q   <= 1'b0;
      res_attr_q  <= '0;
      res_tag_q   <= '0;
    end else begin
      // S_DONE owns the valid flag in its own cycle
      if (rsp_valid_q && rsp_o.ready && state_q != S_DONE) begin
        rsp_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (req_i.valid) begin
            mode_q     <= req_i.mode;
            dev_q      <= req_i.device;
            ino_q      <= req_i.inode;
            attr_in_q  <= req_i.new_attr;
            tag_in_q   <= req_i.new_tag;
            now_q      <= req_i.now_ns;
            x_q        <= req_i.device;
            acc_q      <= req_i.inode;
            step_q     <= '0;
            phase_q    <= 1'b0;
            m_found_q  <= 1'b0;
            vic_done_q <= 1'b0;
            res_hit_q  <= 1'b0;
            res_attr_q <= '0;
            res_tag_q  <= '0;
            state_q    <= skip_item ? S_DONE : S_HASH;
          end
        end

        S_HASH: begin
          if (step_q == 2'd2) begin
            step_q <= '0;
            x_q    <= mix_fold(acc_sum);
            if (!phase_q) begin
              acc_q   <= '0;
              phase_q <= 1'b1;
            end else begin
              bit_cnt_q <= '0;
              r_q       <= '0;
              state_q   <= S_MOD;
            end
          end else begin
            acc_q  <= acc_sum;
            step_q <= step_q + 2'd1;
          end
        end

        S_MOD: begin
          if (SETS_POW2) begin
            base_q  <= set_base(x_q[SET_W-1:0]);
            way_q   <= '0;
            state_q <= S_RD;
          end else if (!step_q[0]) begin
            acc_q  <= mul_p >> MOD_K;
            step_q <= 2'd1;
          end else begin
            r_q       <= r_next;
            x_q       <= {x_q[47:0], 16'd0};
            step_q    <= '0;
            bit_cnt_q <= bit_cnt_q + 2'd1;
            if (bit_cnt_q == 2'd3) begin
              base_q  <= set_base(r_next);
              way_q   <= '0;
              state_q <= S_RD;
            end
          end
        end

        S_RD: begin
          state_q <= S_CMP;
        end

        S_CMP: begin
          if (way_match) begin
            // lowest matching way ends the scan
            m_found_q <= 1'b1;
            m_way_q   <= way_q;
            m_exp_q   <= ram_rdata.expiry;
            m_attr_q  <= ram_rdata.attr;
            m_tag_q   <= ram_rdata.tag;
            state_q   <= S_DECIDE;
          end else begin
            // replacement: first empty way, else earliest expiry (lowest on tie)
            if (!vic_done_q) begin
              if (!ent_valid) begin
                vic_done_q <= 1'b1;
                vic_way_q  <= way_q;
              end else if (way_q == '0 || ram_rdata.expiry < old_exp_q) begin
                vic_way_q <= way_q;
                old_exp_q <= ram_rdata.expiry;
              end
            end
            if (way_q == WAY_W'(NUM_WAYS - 1)) begin
              state_q <= S_DECIDE;
            end else begin
              way_q   <= way_q + WAY_W'(1);
              state_q <= S_RD;
            end
          end
        end

        S_DECIDE: begin
          if (mode_q == MODE_LOOKUP) begin
            if (m_found_q) begin
              if (m_exp_q <= now_q) begin
                valid_q[hit_addr] <= 1'b0;
              end else begin
                res_hit_q  <= 1'b1;
                res_attr_q <= m_attr_q;
                res_tag_q  <= m_tag_q;
              end
            end
            state_q <= S_DONE;
          end else if (mode_q == MODE_STORE) begin
            if (m_found_q) begin
              vic_way_q <= m_way_q;
            end
            state_q <= S_WRITE;
          end else begin
            if (m_found_q) begin
              valid_q[hit_addr] <= 1'b0;
            end
            state_q <= S_DONE;
          end
        end

        S_WRITE: begin
          valid_q[ram_addr] <= 1'b1;
          state_q           <= S_DONE;
        end

        S_DONE: begin
          if (!rsp_valid_q || rsp_o.ready) begin
            rsp_valid_q <= 1'b1;
            rsp_hit_q   <= res_hit_q;
            rsp_attr_q  <= res_attr_q;
            rsp_tag_q   <= res_tag_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.hit        = rsp_hit_q;
  assign rsp_o.found_attr = rsp_attr_q;
  assign rsp_o.found_tag  = rsp_tag_q;

  // ---- assertions ----
  `ASSERT_DFLT(a_write_sets_valid, ram_we |=> valid_q[$past(ram_addr)], "stored entry not valid")
  `ASSERT_DFLT(a_way_bound, state_q == S_CMP |-> way_q <= WAY_W'(NUM_WAYS - 1), "way out of range")
  `ASSERT_DFLT(a_hit_lookup_only, (state_q == S_DONE && mode_q != MODE_LOOKUP) |-> !res_hit_q, "bad hit")
  `ASSERT_DFLT(a_busy_after_accept, req_i.valid && req_i.ready |=> state_q != S_IDLE, "idle after accept")

endmodule
